/* sv/stbp_pkg.sv */
// ----------------------------------------------------------------------------
// stbp_pkg
// Shared types and constants for the spanning-tree bridge port state block.
// ----------------------------------------------------------------------------
package stbp_pkg;

   localparam int ID_W          = 8;
   localparam int DIST_W        = 8;
   localparam int PORT_IDX_W    = 3;
   localparam int PORT_MASK_W   = 8;
   localparam int DEF_NUM_PORTS = 8;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int REQ_DATA_W    = 32;
   localparam int RSP_DATA_W    = 40;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   typedef enum logic [0:0] {
      FUNC_MESSAGE = 1'b0,
      FUNC_TICK    = 1'b1
   } func_type;

   typedef enum logic [0:0] {
      REG_BRIDGE_ID       = 1'b0,
      REG_CONNECTED_PORTS = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ROLE_DESIGNATED = 2'd0,
      ROLE_ROOT       = 2'd1,
      ROLE_BLOCKED    = 2'd2
   } role_type;

   typedef enum logic [1:0] {
      KIND_IGNORE = 2'd0,
      KIND_MSG    = 2'd1,
      KIND_TICK   = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic [ID_W-1:0]          root;
      logic [DIST_W-1:0]        distance;
      logic [ID_W-1:0]          sender;
      logic [PORT_MASK_W-1:0]   port_sel;
   } item_type;

   typedef struct packed {
      logic                     reinit;
      logic [ID_W-1:0]          id;
   } cfg_type;

   typedef struct packed {
      logic                     send;
      logic [ID_W-1:0]          out_root;
      logic [DIST_W-1:0]        out_distance;
      logic [ID_W-1:0]          out_sender;
      logic [PORT_MASK_W-1:0]   tx_ports;
      logic [ID_W-1:0]          best_root;
   } result_type;

endpackage

/* sv/stbp_front.sv */
// ----------------------------------------------------------------------------
// stbp_front
// Decodes an input beat: classifies it as tick, message or ignored message,
// adds a saturating hop to the distance and one-hot selects the arrival port.
// ----------------------------------------------------------------------------
module stbp_front #(
   parameter int NUM_PORTS = stbp_pkg::DEF_NUM_PORTS
) (
   input  logic [stbp_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,
   input  logic [stbp_pkg::PORT_MASK_W-1:0] connected_ports,
   output stbp_pkg::item_type               item
);
   import stbp_pkg::*;

   logic [ID_W-1:0]       msg_root;
   logic [DIST_W-1:0]     msg_distance;
   logic [ID_W-1:0]       msg_sender;
   logic [PORT_IDX_W-1:0] in_port;
   logic                  port_ok;

   assign msg_root     = req_tdata[7:0];
   assign msg_distance = req_tdata[15:8];
   assign msg_sender   = req_tdata[23:16];
   assign in_port      = req_tdata[26:24];

   assign port_ok = (32'(in_port) < NUM_PORTS) && connected_ports[in_port];

   always_comb begin
      item.root     = msg_root;
      item.sender   = msg_sender;
      item.distance = (msg_distance == DIST_MAX) ? DIST_MAX : msg_distance + 1'b1;
      item.port_sel = PORT_MASK_W'(1) << in_port;
      if (req_tuser == FUNC_TICK) begin
         item.kind = KIND_TICK;
      end else if (port_ok) begin
         item.kind = KIND_MSG;
      end else begin
         item.kind = KIND_IGNORE;
      end
   end

endmodule

/* sv/stbp_queue.sv */
// ----------------------------------------------------------------------------
// stbp_queue
// Two-entry queue of classified items between the front and back halves.
// ----------------------------------------------------------------------------
module stbp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  stbp_pkg::item_type  push_item,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output stbp_pkg::item_type  head_item
);
   import stbp_pkg::*;

   item_type    mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* sv/stbp_back.sv */
// ----------------------------------------------------------------------------
// stbp_back
// Holds root state and port roles, applies one item per cycle while the
// response register is free or being taken, and drives the result register.
// ----------------------------------------------------------------------------
module stbp_back #(
   parameter int NUM_PORTS = stbp_pkg::DEF_NUM_PORTS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [stbp_pkg::ID_W-1:0]        bridge_id,
   input  logic [stbp_pkg::PORT_MASK_W-1:0] connected_ports,
   input  stbp_pkg::cfg_type                cfg,
   input  logic                             head_valid,
   input  stbp_pkg::item_type               head_item,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output stbp_pkg::result_type             rsp_result
);
   import stbp_pkg::*;

   localparam int LIVE_PORTS = (NUM_PORTS < PORT_MASK_W) ? NUM_PORTS : PORT_MASK_W;

   logic [ID_W-1:0]    root_id_ff, root_id_in;
   logic [DIST_W-1:0]  root_dist_ff, root_dist_in;
   logic [ID_W-1:0]    root_sender_ff, root_sender_in;
   role_type           role_ff [NUM_PORTS];
   role_type           role_in [NUM_PORTS];
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         result_ff, result_in;

   logic [NUM_PORTS-1:0]   sel;
   role_type               cur_role;
   logic                   better;
   logic                   blocked;
   logic                   fwd;
   logic [PORT_MASK_W-1:0] excl;
   logic [PORT_MASK_W-1:0] live;
   logic [PORT_MASK_W-1:0] tx;
   logic [ID_W-1:0]        o_root;
   logic [DIST_W-1:0]      o_dist;

   assign pop        = head_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

   always_comb begin
      for (int p = 0; p < NUM_PORTS; p++) begin
         sel[p] = (p < PORT_MASK_W) ? head_item.port_sel[PORT_IDX_W'(p)] : 1'b0;
      end
      cur_role = ROLE_DESIGNATED;
      for (int p = 0; p < NUM_PORTS; p++) begin
         if (sel[p]) begin
            cur_role = role_ff[p];
         end
      end

      root_id_in     = root_id_ff;
      root_dist_in   = root_dist_ff;
      root_sender_in = root_sender_ff;
      for (int p = 0; p < NUM_PORTS; p++) begin
         role_in[p] = role_ff[p];
      end

      better  = (head_item.root < root_id_ff) || (head_item.distance < root_dist_ff) ||
                ((head_item.distance == root_dist_ff) &&
                 (head_item.sender < root_sender_ff));
      blocked = 1'b0;
      fwd     = 1'b0;
      excl    = '0;
      o_root  = '0;
      o_dist  = '0;

      if (pop) begin
         unique case (head_item.kind)
            KIND_TICK: begin
               if (root_id_ff == bridge_id) begin
                  fwd    = 1'b1;
                  o_root = bridge_id;
               end
            end
            KIND_MSG: begin
               if (head_item.root <= root_id_ff) begin
                  if (better) begin
                     root_id_in     = head_item.root;
                     root_dist_in   = head_item.distance;
                     root_sender_in = head_item.sender;
                     for (int p = 0; p < NUM_PORTS; p++) begin
                        if (sel[p]) begin
                           role_in[p] = ROLE_ROOT;
                        end else if (role_ff[p] == ROLE_ROOT) begin
                           role_in[p] = ROLE_DESIGNATED;
                        end
                     end
                  end else if (cur_role != ROLE_ROOT && bridge_id > head_item.sender) begin
                     blocked = 1'b1;
                     for (int p = 0; p < NUM_PORTS; p++) begin
                        if (sel[p]) begin
                           role_in[p] = ROLE_BLOCKED;
                        end
                     end
                  end else begin
                     blocked = (cur_role == ROLE_BLOCKED);
                  end
                  if (!blocked) begin
                     fwd    = 1'b1;
                     excl   = head_item.port_sel;
                     o_root = head_item.root;
                     o_dist = head_item.distance;
                  end
               end
            end
            KIND_IGNORE: begin
            end
            default: begin
            end
         endcase
      end

      live = '0;
      for (int p = 0; p < LIVE_PORTS; p++) begin
         live[p] = connected_ports[p] && (role_in[p] != ROLE_BLOCKED);
      end
      tx = fwd ? (live & ~excl) : '0;

      result_in.send         = |tx;
      result_in.out_root     = (|tx) ? o_root : '0;
      result_in.out_distance = (|tx) ? o_dist : '0;
      result_in.out_sender   = (|tx) ? bridge_id : '0;
      result_in.tx_ports     = tx;
      result_in.best_root    = root_id_in;

      if (cfg.reinit) begin
         root_id_in     = cfg.id;
         root_dist_in   = '0;
         root_sender_in = cfg.id;
         for (int p = 0; p < NUM_PORTS; p++) begin
            role_in[p] = ROLE_DESIGNATED;
         end
      end

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_id_ff     <= '0;
         root_dist_ff   <= '0;
         root_sender_ff <= '0;
         for (int p = 0; p < NUM_PORTS; p++) begin
            role_ff[p] <= ROLE_DESIGNATED;
         end
         rsp_valid_ff   <= 1'b0;
      end else begin
         root_id_ff     <= root_id_in;
         root_dist_ff   <= root_dist_in;
         root_sender_ff <= root_sender_in;
         for (int p = 0; p < NUM_PORTS; p++) begin
            role_ff[p] <= role_in[p];
         end
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= result_in;
      end
   end

endmodule

/* sv/spanning_tree_bridge_port_state.sv */
// ----------------------------------------------------------------------------
// spanning_tree_bridge_port_state
// One bridge of a simplified spanning-tree protocol: root election, port
// roles and message forwarding, with an APB-style register port.
// Throughput: one beat per cycle while rsp_tready is not held low; the back
// stage applies one item per cycle to the root state and registers its
// response beat, and a two-entry queue decouples it from the input side.
// Reset: synchronous; root state cleared to bridge_id 0, all ports designated.
// ----------------------------------------------------------------------------
module spanning_tree_bridge_port_state #(
   parameter int NUM_PORTS = stbp_pkg::DEF_NUM_PORTS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // msg_root[7:0], msg_distance[15:8], msg_sender[23:16], in_port[26:24]
   input  logic [stbp_pkg::REQ_DATA_W-1:0]  req_tdata,
   // func[0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_root[7:0], out_distance[15:8], out_sender[23:16], tx_ports[31:24],
   // best_root[39:32]
   output logic [stbp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // send[0]
   output logic                             rsp_tuser,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [stbp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [stbp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [stbp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import stbp_pkg::*;

   logic [ID_W-1:0]        bridge_id_ff, bridge_id_in;
   logic [PORT_MASK_W-1:0] connected_ff, connected_in;
   logic                   csr_write;
   reg_index_type          csr_index;
   cfg_type                cfg;
   item_type               front_item;
   item_type               head_item;
   logic                   queue_full;
   logic                   head_valid;
   logic                   pop;
   result_type             result;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   always_comb begin
      bridge_id_in = bridge_id_ff;
      connected_in = connected_ff;
      cfg.reinit   = 1'b0;
      cfg.id       = csr_pwdata[ID_W-1:0];
      if (csr_write) begin
         unique case (csr_index)
            REG_BRIDGE_ID: begin
               bridge_id_in = csr_pwdata[ID_W-1:0];
               cfg.reinit   = 1'b1;
            end
            REG_CONNECTED_PORTS: begin
               connected_in = csr_pwdata[PORT_MASK_W-1:0];
            end
            default: begin
            end
         endcase
      end
      unique case (csr_index)
         REG_BRIDGE_ID:       csr_prdata = CSR_DATA_W'(bridge_id_ff);
         REG_CONNECTED_PORTS: csr_prdata = CSR_DATA_W'(connected_ff);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bridge_id_ff <= '0;
         connected_ff <= '0;
      end else begin
         bridge_id_ff <= bridge_id_in;
         connected_ff <= connected_in;
      end
   end

   assign req_tready = !queue_full;

   stbp_front #(
      .NUM_PORTS (NUM_PORTS)
   ) u_front (
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .connected_ports (connected_ff),
      .item            (front_item)
   );

   stbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid && req_tready),
      .push_item  (front_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   stbp_back #(
      .NUM_PORTS (NUM_PORTS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .bridge_id       (bridge_id_ff),
      .connected_ports (connected_ff),
      .cfg             (cfg),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .pop             (pop),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_result      (result)
   );

   assign rsp_tuser = result.send;
   assign rsp_tdata = {result.best_root, result.tx_ports, result.out_sender,
                       result.out_distance, result.out_root};

endmodule

/* tb/spanning_tree_bridge_port_state_test.sv */
// ----------------------------------------------------------------------------
// spanning_tree_bridge_port_state_test
// Self-checking bench for the bridge port state block. A directed opening
// walks root takeover, shorter paths, lower senders, port blocking, distance
// saturation, ticks and unconnected ports; random phases then run message
// streams built around the current root under many register settings, with
// random request gaps and response stalls. A scoreboard tracks the root state
// and compares every response beat, field by field, with its prediction.
// ----------------------------------------------------------------------------
module spanning_tree_bridge_port_state_test;
   timeunit 1ns;
   timeprecision 1ps;

   import stbp_pkg::*;

   localparam int HOLD_OFF_CYCLES = 80;
   localparam int PHASES          = 13;
   localparam int PHASE_TARGET    = 100;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   bit hold_off_req;
   bit tight_sender;
   int settings_used;

   class root_election_scoreboard;
      logic [ID_W-1:0]        own_id;
      logic [PORT_MASK_W-1:0] attached;
      logic [ID_W-1:0]        best_id;
      logic [DIST_W-1:0]      best_dist;
      logic [ID_W-1:0]        best_via;
      logic [PORT_IDX_W-1:0]  upstream_port;
      role_type               role_of [DEF_NUM_PORTS];
      result_type             due_results [$];
      int                     mismatches;
      int                     checked;
      int                     forwarded;
      int                     noted;
      int                     blockings;

      function new();
         own_id     = '0;
         attached   = '0;
         mismatches = 0;
         checked    = 0;
         forwarded  = 0;
         noted      = 0;
         blockings  = 0;
         restart();
      endfunction

      function void restart();
         best_id       = own_id;
         best_dist     = '0;
         best_via      = own_id;
         upstream_port = '0;
         foreach (role_of[p]) role_of[p] = ROLE_DESIGNATED;
      endfunction

      function void write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_BRIDGE_ID: begin
               own_id = value[ID_W-1:0];
               restart();
            end
            REG_CONNECTED_PORTS: attached = value[PORT_MASK_W-1:0];
            default: begin
            end
         endcase
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function logic [PORT_MASK_W-1:0] live_ports();
         logic [PORT_MASK_W-1:0] live;
         live = '0;
         foreach (role_of[p]) live[p] = attached[p] && (role_of[p] != ROLE_BLOCKED);
         return live;
      endfunction

      function void note_request(func_type f, logic [ID_W-1:0] root,
                                 logic [DIST_W-1:0] distance,
                                 logic [ID_W-1:0] sender, logic [PORT_IDX_W-1:0] port);
         result_type             want;
         logic [PORT_MASK_W-1:0] tx;
         logic [DIST_W-1:0]      hop;
         want = '0;
         tx   = '0;
         noted++;
         if (f == FUNC_TICK) begin
            if (best_id == own_id) begin
               tx                = live_ports();
               want.out_root     = own_id;
               want.out_distance = '0;
            end
         end else if (attached[port] && root <= best_id) begin
            hop = (distance == DIST_MAX) ? DIST_MAX : distance + 1'b1;
            if (root < best_id || hop < best_dist || (hop == best_dist && sender < best_via)) begin
               best_id       = root;
               best_dist     = hop;
               best_via      = sender;
               upstream_port = port;
               foreach (role_of[p]) if (role_of[p] == ROLE_ROOT) role_of[p] = ROLE_DESIGNATED;
               role_of[port] = ROLE_ROOT;
            end else if (role_of[port] != ROLE_ROOT && own_id > sender) begin
               role_of[port] = ROLE_BLOCKED;
               blockings++;
            end
            if (role_of[port] != ROLE_BLOCKED) begin
               tx                = live_ports();
               tx[port]          = 1'b0;
               want.out_root     = root;
               want.out_distance = hop;
            end
         end
         if (tx != '0) begin
            want.send       = 1'b1;
            want.out_sender = own_id;
            want.tx_ports   = tx;
         end else begin
            want.out_root     = '0;
            want.out_distance = '0;
         end
         want.best_root = best_id;
         due_results = {due_results, want};
      endfunction

      function void fault(string what);
         mismatches++;
         if (mismatches <= 10) $display("%0t ns  %s", $time, what);
      endfunction

      function string show(result_type r);
         return $sformatf("send=%0d root=%h dist=%h sender=%h tx=%h best=%h",
                          r.send, r.out_root, r.out_distance, r.out_sender,
                          r.tx_ports, r.best_root);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data, logic send);
         result_type got;
         result_type want;
         got.send         = send;
         got.out_root     = data[7:0];
         got.out_distance = data[15:8];
         got.out_sender   = data[23:16];
         got.tx_ports     = data[31:24];
         got.best_root    = data[39:32];
         checked++;
         if (send) forwarded++;
         if (due_results.size() == 0) begin
            fault({"response beat with nothing due: ", show(got)});
            return;
         end
         want = due_results.pop_front();
         if (got !== want) fault({"expected ", show(want), " got ", show(got)});
      endfunction
   endclass

   root_election_scoreboard sb;

   spanning_tree_bridge_port_state dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("spanning_tree_bridge_port_state regression: fail");
      $finish;
   end

   initial begin : rsp_sink
      int unsigned low_left;
      int unsigned mode_left;
      int unsigned r;
      bit          steady;
      low_left   = 0;
      mode_left  = 0;
      steady     = 1'b0;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            if (mode_left == 0) begin
               steady    = ($urandom_range(0, 2) == 0);
               mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (low_left != 0) begin
               low_left--;
               rsp_tready <= 1'b0;
            end else if (steady) begin
               rsp_tready <= 1'b1;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 75) begin
                  rsp_tready <= 1'b1;
               end else begin
                  rsp_tready <= 1'b0;
                  low_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
   end

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic logic [7:0] near(int base, int spread);
      int v;
      v = base + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      else if (v > 255) v = 255;
      return v[7:0];
   endfunction

   function automatic void draw_item(output func_type f, output logic [ID_W-1:0] root,
                                     output logic [DIST_W-1:0] distance,
                                     output logic [ID_W-1:0] sender,
                                     output logic [PORT_IDX_W-1:0] port);
      int unsigned r;
      f    = ($urandom_range(0, 99) < 10) ? FUNC_TICK : FUNC_MESSAGE;
      port = PORT_IDX_W'($urandom_range(0, 7));
      if (sb.attached != '0 && $urandom_range(0, 9) < 8)
         while (!sb.attached[port]) port = PORT_IDX_W'($urandom_range(0, 7));
      r = $urandom_range(0, 99);
      if (r < 55)      root = sb.best_id;
      else if (r < 65) root = near(int'(sb.best_id) - 2, 1);
      else if (r < 75) root = ID_W'($urandom);
      else if (r < 95) root = near(int'(sb.best_id) + 1, 0);
      else             root = 8'h00;
      r = $urandom_range(0, 99);
      if (r < 60)      distance = near(int'(sb.best_dist) - 1, 2);
      else if (r < 75) distance = DIST_W'($urandom_range(0, 3));
      else if (r < 85) distance = DIST_W'($urandom_range(253, 255));
      else             distance = DIST_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 40)      sender = near(sb.own_id, 2);
      else if (r < 70) sender = near(sb.best_via, 1);
      else if (r < 85) sender = ID_W'($urandom);
      else             sender = $urandom_range(0, 1) ? 8'hFF : 8'h00;
   endfunction

   task automatic put(func_type f, logic [ID_W-1:0] root, logic [DIST_W-1:0] distance,
                      logic [ID_W-1:0] sender, logic [PORT_IDX_W-1:0] port);
      int unsigned gap;
      gap = tight_sender ? 0 : gap_len();
      if (gap != 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= REQ_DATA_W'({port, sender, distance, root});
      do @(posedge clock); while (!req_tready);
      sb.note_request(f, root, distance, sender, port);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_access(reg_index_type idx, logic write, logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] want;
      want = '0;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (write) begin
         sb.write_reg(idx, value);
      end else begin
         if (idx == REG_BRIDGE_ID) want[ID_W-1:0] = sb.own_id;
         else want[PORT_MASK_W-1:0] = sb.attached;
         if (csr_prdata !== want)
            sb.fault($sformatf("register %s read %h, expected %h", idx.name(), csr_prdata, want));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic configure(logic [ID_W-1:0] id, logic [PORT_MASK_W-1:0] ports);
      drain();
      repeat (4) @(posedge clock);
      csr_access(REG_CONNECTED_PORTS, 1'b1, CSR_DATA_W'(ports));
      csr_access(REG_BRIDGE_ID, 1'b1, CSR_DATA_W'(id));
      csr_access(REG_CONNECTED_PORTS, 1'b0, '0);
      csr_access(REG_BRIDGE_ID, 1'b0, '0);
      settings_used++;
   endtask

   initial begin
      func_type              f;
      logic [ID_W-1:0]       root;
      logic [DIST_W-1:0]     distance;
      logic [ID_W-1:0]       sender;
      logic [PORT_IDX_W-1:0] port;
      logic [ID_W-1:0]       id;
      logic [PORT_MASK_W-1:0] ports;
      int                    target;
      int                    attempts;
      bit                    paused;

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      hold_off_req = 1'b0;
      tight_sender = 1'b0;
      settings_used = 0;
      paused       = 1'b0;
      sb = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      configure(8'h80, 8'h7F);
      put(FUNC_TICK,    8'h00, 8'h00, 8'h00, 3'd0);
      put(FUNC_MESSAGE, 8'h10, 8'h03, 8'h11, 3'd7);
      put(FUNC_MESSAGE, 8'h90, 8'h01, 8'h20, 3'd1);
      put(FUNC_MESSAGE, 8'h40, 8'h03, 8'h41, 3'd2);
      put(FUNC_MESSAGE, 8'h40, 8'h03, 8'h42, 3'd3);
      put(FUNC_TICK,    8'hFF, 8'hFF, 8'hFF, 3'd7);
      put(FUNC_MESSAGE, 8'h40, 8'h02, 8'h50, 3'd4);
      put(FUNC_MESSAGE, 8'h40, 8'h02, 8'h30, 3'd5);
      put(FUNC_MESSAGE, 8'h40, 8'h09, 8'h90, 3'd3);
      put(FUNC_MESSAGE, 8'h00, 8'hFF, 8'hFF, 3'd0);
      put(FUNC_MESSAGE, 8'h00, 8'hFE, 8'h01, 3'd1);
      put(FUNC_MESSAGE, 8'h00, 8'h00, 8'h00, 3'd6);
      put(FUNC_MESSAGE, 8'h00, 8'h05, 8'hFF, 3'd0);
      put(FUNC_MESSAGE, 8'h00, 8'h00, 8'h00, 3'd6);
      put(FUNC_MESSAGE, 8'h00, 8'h00, 8'h7F, 3'd1);
      put(FUNC_MESSAGE, 8'hFF, 8'h00, 8'h00, 3'd2);
      put(FUNC_TICK,    8'h00, 8'h00, 8'h00, 3'd0);

      configure(8'hFF, 8'h80);
      put(FUNC_TICK,    8'h00, 8'h00, 8'h00, 3'd0);
      put(FUNC_MESSAGE, 8'h00, 8'h00, 8'h00, 3'd7);
      put(FUNC_TICK,    8'h00, 8'h00, 8'h00, 3'd0);

      configure(8'h00, 8'h00);
      put(FUNC_TICK,    8'h00, 8'h00, 8'h00, 3'd0);
      put(FUNC_MESSAGE, 8'h00, 8'h00, 8'h00, 3'd0);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin id = 8'h00; ports = 8'hFF; end
            1: begin id = 8'hFF; ports = 8'hFF; end
            3: begin id = ID_W'($urandom); ports = 8'h00; end
            default: begin
               id    = ID_W'($urandom);
               ports = PORT_MASK_W'($urandom_range(1, 255));
            end
         endcase
         configure(id, ports);
         target       = (p == 3) ? 20 : PHASE_TARGET;
         tight_sender = (p == 2) || ($urandom_range(0, 3) == 0);
         if (p == 2) hold_off_req = 1'b1;
         attempts = 0;
         while (attempts < target) begin
            if (p == 4 && !paused && attempts == target / 2) begin
               drain();
               paused = 1'b1;
            end
            draw_item(f, root, distance, sender, port);
            attempts++;
            put(f, root, distance, sender, port);
         end
      end

      drain();
      repeat (8) @(posedge clock);
      $display("%0d request beats over %0d register settings, %0d response beats checked",
               sb.noted, settings_used, sb.checked);
      $display("%0d responses forwarded a message, %0d ports blocked by a lower sender",
               sb.forwarded, sb.blockings);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("spanning_tree_bridge_port_state regression: pass");
      else
         $display("spanning_tree_bridge_port_state regression: fail");
      $finish;
   end

endmodule

/* filelist.f */
sv/stbp_pkg.sv
sv/stbp_front.sv
sv/stbp_queue.sv
sv/stbp_back.sv
sv/spanning_tree_bridge_port_state.sv
tb/spanning_tree_bridge_port_state_test.sv
